### hw/rtl/swrr_pkg.sv
// ----------------------------------------------------------------------------
// swrr_pkg
// shared types, codes and constants of the smooth weighted round-robin unit
// ----------------------------------------------------------------------------
package swrr_pkg;

    // item field widths
    localparam int OP_W     = 2;
    localparam int GROUP_W  = 4;
    localparam int PEER_W   = 4;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int CHOSEN_W = 4;
    localparam int GCOUNT_W = 5;

    // running weights are 32-bit two's complement
    localparam int RW_BITS = 32;

    // holds any group or peer index up to 511
    localparam int IDX_W = 9;

    // parameter defaults
    localparam int DEF_MAX_GROUPS  = 16;
    localparam int DEF_MAX_PEERS   = 16;
    localparam int DEF_WEIGHT_BITS = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_SELECT       = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_WEIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_COUNT    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STS_SELECTED   = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NO_GROUP   = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY      = 2'd2;
    localparam logic [STATUS_W-1:0] STS_WRITE_DONE = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WALK,
        ST_FIX,
        ST_ROWCLR,
        ST_DONE
    } t_state;

    // memory strobes from the sequencer
    typedef struct packed {
        logic wt_we;
        logic rw_we;
        logic slot_re;
        logic cnt_we;
        logic cnt_re;
    } t_mem_ctl;

    // address bits for a count of entries, at least one
    function automatic int index_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

### hw/rtl/swrr_req_if.sv
// ----------------------------------------------------------------------------
// swrr_req_if
// request channel: select, weight write or peer count write
// ----------------------------------------------------------------------------
interface swrr_req_if import swrr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [GROUP_W-1:0]  group;
    logic [PEER_W-1:0]   peer;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output operation, output group, output peer,
                    output value, input ready);
    modport sink   (input valid, input operation, input group, input peer,
                    input value, output ready);
endinterface

### hw/rtl/swrr_rsp_if.sv
// ----------------------------------------------------------------------------
// swrr_rsp_if
// response channel: status and chosen peer
// ----------------------------------------------------------------------------
interface swrr_rsp_if import swrr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CHOSEN_W-1:0] chosen_peer;

    modport source (output valid, output status, output chosen_peer, input ready);
    modport sink   (input valid, input status, input chosen_peer, output ready);
endinterface

### hw/rtl/swrr_cfg_if.sv
// ----------------------------------------------------------------------------
// swrr_cfg_if
// configuration write channel for the group count register
// ----------------------------------------------------------------------------
interface swrr_cfg_if import swrr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [GCOUNT_W-1:0] group_count;

    modport source (output valid, output group_count, input ready);
    modport sink   (input valid, input group_count, output ready);
endinterface

### hw/rtl/swrr_mem.sv
// ----------------------------------------------------------------------------
// swrr_mem
// weight, running weight and peer count memories, registered reads
// ----------------------------------------------------------------------------
module swrr_mem import swrr_pkg::*; #(
    parameter int MAX_GROUPS  = DEF_MAX_GROUPS,
    parameter int MAX_PEERS   = DEF_MAX_PEERS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
    localparam int GB = index_bits(MAX_GROUPS),
    localparam int PB = index_bits(MAX_PEERS),
    localparam int CB = $clog2(MAX_PEERS + 1),
    localparam int SB = GB + PB
) (
    input  logic                   i_clk,
    input  t_mem_ctl               i_ctl,
    input  logic [SB-1:0]          i_slot_waddr,
    input  logic [SB-1:0]          i_slot_raddr,
    input  logic [WEIGHT_BITS-1:0] i_wt_wdata,
    input  logic [RW_BITS-1:0]     i_rw_wdata,
    input  logic [GB-1:0]          i_cnt_addr,
    input  logic [CB-1:0]          i_cnt_wdata,
    output logic [WEIGHT_BITS-1:0] o_wt_rdata,
    output logic [RW_BITS-1:0]     o_rw_rdata,
    output logic [CB-1:0]          o_cnt_rdata
);

    localparam int SLOTS  = 1 << SB;
    localparam int GROUPS = 1 << GB;

    logic [WEIGHT_BITS-1:0] r_wt_mem  [SLOTS];
    logic [RW_BITS-1:0]     r_rw_mem  [SLOTS];
    logic [CB-1:0]          r_cnt_mem [GROUPS];

    logic [WEIGHT_BITS-1:0] r_wt_rdata;
    logic [RW_BITS-1:0]     r_rw_rdata;
    logic [CB-1:0]          r_cnt_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wt_we) begin
            r_wt_mem[i_slot_waddr] <= i_wt_wdata;
        end
        if (i_ctl.slot_re) begin
            r_wt_rdata <= r_wt_mem[i_slot_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rw_we) begin
            r_rw_mem[i_slot_waddr] <= i_rw_wdata;
        end
        if (i_ctl.slot_re) begin
            r_rw_rdata <= r_rw_mem[i_slot_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cnt_we) begin
            r_cnt_mem[i_cnt_addr] <= i_cnt_wdata;
        end
        if (i_ctl.cnt_re) begin
            r_cnt_rdata <= r_cnt_mem[i_cnt_addr];
        end
    end

    assign o_wt_rdata  = r_wt_rdata;
    assign o_rw_rdata  = r_rw_rdata;
    assign o_cnt_rdata = r_cnt_rdata;

endmodule

### hw/rtl/swrr_ctrl.sv
// ----------------------------------------------------------------------------
// swrr_ctrl
// request sequencer: clearing pass, weight walk, write-back, row clear and response register
// ----------------------------------------------------------------------------
module swrr_ctrl import swrr_pkg::*; #(
    parameter int MAX_GROUPS  = DEF_MAX_GROUPS,
    parameter int MAX_PEERS   = DEF_MAX_PEERS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
    localparam int GB = index_bits(MAX_GROUPS),
    localparam int PB = index_bits(MAX_PEERS),
    localparam int CB = $clog2(MAX_PEERS + 1),
    localparam int SB = GB + PB
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [GCOUNT_W-1:0]    i_group_count,
    swrr_req_if.sink               i_req,
    swrr_rsp_if.source             o_rsp,
    output t_mem_ctl               o_mem_ctl,
    output logic [SB-1:0]          o_slot_waddr,
    output logic [SB-1:0]          o_slot_raddr,
    output logic [WEIGHT_BITS-1:0] o_wt_wdata,
    output logic [RW_BITS-1:0]     o_rw_wdata,
    output logic [GB-1:0]          o_cnt_addr,
    output logic [CB-1:0]          o_cnt_wdata,
    input  logic [WEIGHT_BITS-1:0] i_wt_rdata,
    input  logic [RW_BITS-1:0]     i_rw_rdata,
    input  logic [CB-1:0]          i_cnt_rdata
);

    t_state r_state, n_state;

    logic [SB-1:0]       r_sweep, n_sweep;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [CHOSEN_W-1:0] r_out_chosen, n_out_chosen;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [CHOSEN_W-1:0] r_res_chosen, n_res_chosen;
    logic [GB-1:0]       r_group, n_group;
    logic [CB-1:0]       r_n, n_n;
    logic [CB-1:0]       r_rd_idx, n_rd_idx;
    logic [PB-1:0]       r_proc, n_proc;
    logic [PB-1:0]       r_best, n_best;
    logic [RW_BITS-1:0]  r_best_val, n_best_val;
    logic [RW_BITS-1:0]  r_total, n_total;
    logic [PB-1:0]       r_clr, n_clr;

    logic [IDX_W-1:0]    g_ext, p_ext, best_ext;
    logic                g_in_mem, g_used, p_ok;
    logic [GB-1:0]       g_idx;
    logic [PB-1:0]       p_idx;
    logic [31:0]         v_ext;
    logic [CB-1:0]       cnt_sat;
    logic [RW_BITS-1:0]  wt_ext, sum;

    // request field decode
    always_comb begin
        g_ext    = IDX_W'(i_req.group);
        p_ext    = IDX_W'(i_req.peer);
        g_in_mem = g_ext < IDX_W'(MAX_GROUPS);
        g_used   = g_in_mem && ({1'b0, i_req.group} < i_group_count);
        p_ok     = p_ext < IDX_W'(MAX_PEERS);
        g_idx    = g_ext[GB-1:0];
        p_idx    = p_ext[PB-1:0];
        v_ext    = 32'(i_req.value);
        cnt_sat  = (i_req.value > VALUE_W'(MAX_PEERS)) ? CB'(MAX_PEERS)
                                                        : i_req.value[CB-1:0];
        wt_ext   = RW_BITS'(i_wt_rdata);
        sum      = i_rw_rdata + wt_ext;
        best_ext = IDX_W'(r_best);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_chosen <= n_out_chosen;
        r_res_status <= n_res_status;
        r_res_chosen <= n_res_chosen;
        r_group      <= n_group;
        r_n          <= n_n;
        r_rd_idx     <= n_rd_idx;
        r_proc       <= n_proc;
        r_best       <= n_best;
        r_best_val   <= n_best_val;
        r_total      <= n_total;
        r_clr        <= n_clr;
    end

    always_comb begin
        n_state      = r_state;
        n_sweep      = r_sweep;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_chosen = r_out_chosen;
        n_res_status = r_res_status;
        n_res_chosen = r_res_chosen;
        n_group      = r_group;
        n_n          = r_n;
        n_rd_idx     = r_rd_idx;
        n_proc       = r_proc;
        n_best       = r_best;
        n_best_val   = r_best_val;
        n_total      = r_total;
        n_clr        = r_clr;

        o_mem_ctl    = '0;
        o_slot_waddr = {r_group, r_proc};
        o_slot_raddr = {r_group, r_rd_idx[PB-1:0]};
        o_wt_wdata   = '0;
        o_rw_wdata   = '0;
        o_cnt_addr   = r_group;
        o_cnt_wdata  = '0;
        i_req.ready  = 1'b0;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                // zero every slot, and each group count on its first slot
                o_mem_ctl.wt_we  = 1'b1;
                o_mem_ctl.rw_we  = 1'b1;
                o_mem_ctl.cnt_we = (r_sweep[PB-1:0] == '0);
                o_slot_waddr     = r_sweep;
                o_cnt_addr       = r_sweep[SB-1:PB];
                n_sweep          = r_sweep + 1'b1;
                if (&r_sweep) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                i_req.ready  = 1'b1;
                n_res_chosen = '0;
                n_res_status = STS_WRITE_DONE;
                if (i_req.valid) begin
                    n_state = ST_DONE;
                    unique case (i_req.operation)
                        OP_SELECT: begin
                            if (!g_used) begin
                                n_res_status = STS_NO_GROUP;
                            end else begin
                                o_mem_ctl.cnt_re = 1'b1;
                                o_cnt_addr       = g_idx;
                                n_group          = g_idx;
                                n_state          = ST_LOOKUP;
                            end
                        end
                        OP_WRITE_WEIGHT: begin
                            o_mem_ctl.wt_we = g_in_mem && p_ok;
                            o_slot_waddr    = {g_idx, p_idx};
                            o_wt_wdata      = v_ext[WEIGHT_BITS-1:0];
                        end
                        OP_SET_COUNT: begin
                            if (g_in_mem) begin
                                o_mem_ctl.cnt_we = 1'b1;
                                o_cnt_addr       = g_idx;
                                o_cnt_wdata      = cnt_sat;
                                n_group          = g_idx;
                                n_clr            = '0;
                                n_state          = ST_ROWCLR;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                n_res_chosen = '0;
                if (i_cnt_rdata == '0) begin
                    n_res_status = STS_EMPTY;
                    n_state      = ST_DONE;
                end else if (i_cnt_rdata == CB'(1)) begin
                    n_res_status = STS_SELECTED;
                    n_state      = ST_DONE;
                end else begin
                    // start the walk with peer 0
                    o_mem_ctl.slot_re = 1'b1;
                    o_slot_raddr      = {r_group, {PB{1'b0}}};
                    n_n               = i_cnt_rdata;
                    n_rd_idx          = CB'(1);
                    n_proc            = '0;
                    n_total           = '0;
                    n_state           = ST_WALK;
                end
            end
            ST_WALK: begin
                // data for r_proc is here; read of the next peer overlaps
                o_mem_ctl.rw_we = 1'b1;
                o_slot_waddr    = {r_group, r_proc};
                o_rw_wdata      = sum;
                n_total         = r_total + wt_ext;
                if (r_proc == '0 || $signed(sum) > $signed(r_best_val)) begin
                    n_best     = r_proc;
                    n_best_val = sum;
                end
                if (r_rd_idx < r_n) begin
                    o_mem_ctl.slot_re = 1'b1;
                    n_rd_idx          = r_rd_idx + 1'b1;
                end
                n_proc = r_proc + 1'b1;
                if (CB'(r_proc) + CB'(1) == r_n) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                o_mem_ctl.rw_we = 1'b1;
                o_slot_waddr    = {r_group, r_best};
                o_rw_wdata      = r_best_val - r_total;
                n_res_status    = STS_SELECTED;
                n_res_chosen    = best_ext[CHOSEN_W-1:0];
                n_state         = ST_DONE;
            end
            ST_ROWCLR: begin
                o_mem_ctl.rw_we = 1'b1;
                o_slot_waddr    = {r_group, r_clr};
                n_clr           = r_clr + 1'b1;
                if (r_clr == PB'(MAX_PEERS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_chosen = r_res_chosen;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.chosen_peer = r_out_chosen;

    a_no_slot_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_ctl.slot_re && o_mem_ctl.rw_we) |-> (o_slot_raddr != o_slot_waddr))
        else $error("running weight read and write hit the same slot");

    a_walk_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (CB'(r_proc) < r_n))
        else $error("walk index past the group peer count");

    a_fix_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIX) |-> ($past(r_state) == ST_WALK))
        else $error("write-back without a walk");

    a_chosen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != STS_SELECTED) |-> (r_out_chosen == '0))
        else $error("chosen peer set on a non-select response");

endmodule

### hw/rtl/smooth_weighted_round_robin_unit.sv
// steps: a select runs lookup, a walk of the group's peers (one peer a cycle), write-back and
//   done; an empty or single-peer group ends after lookup; an out-of-range select or a weight
//   write goes straight to done; a count write clears the group's MAX_PEERS running weights
// throughput: one request at a time, next request taken in the cycle after the response
//   is registered, even while that response is still waiting; reset: synchronous active-low;
//   a pass over all 2^(GB+PB) slots (256 at defaults) zeroes all memories before any request
// ----------------------------------------------------------------------------
// smooth_weighted_round_robin_unit
// smooth weighted round-robin peer selector over memory-resident group state
// ----------------------------------------------------------------------------
module smooth_weighted_round_robin_unit import swrr_pkg::*; #(
    parameter int MAX_GROUPS  = DEF_MAX_GROUPS,
    parameter int MAX_PEERS   = DEF_MAX_PEERS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swrr_req_if.sink   i_req,
    swrr_rsp_if.source o_rsp,
    swrr_cfg_if.sink   i_cfg
);

    localparam int GB = index_bits(MAX_GROUPS);
    localparam int PB = index_bits(MAX_PEERS);
    localparam int CB = $clog2(MAX_PEERS + 1);
    localparam int SB = GB + PB;

    // groups in use; compared against the request group on each select
    logic [GCOUNT_W-1:0] r_group_count;

    // memory port wiring between sequencer and storage
    t_mem_ctl               mem_ctl;
    logic [SB-1:0]          slot_waddr;
    logic [SB-1:0]          slot_raddr;
    logic [WEIGHT_BITS-1:0] wt_wdata;
    logic [WEIGHT_BITS-1:0] wt_rdata;
    logic [RW_BITS-1:0]     rw_wdata;
    logic [RW_BITS-1:0]     rw_rdata;
    logic [GB-1:0]          cnt_addr;
    logic [CB-1:0]          cnt_wdata;
    logic [CB-1:0]          cnt_rdata;

    // config writes must only arrive while idle (the user's duty, not enforced here); the port never stalls
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_count <= '0;
        end else if (i_cfg.valid) begin
            r_group_count <= i_cfg.group_count;
        end
    end

    // sequencer: clearing pass, select walk, row clear and response register
    swrr_ctrl #(
        .MAX_GROUPS  (MAX_GROUPS),
        .MAX_PEERS   (MAX_PEERS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_group_count (r_group_count),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .o_mem_ctl     (mem_ctl),
        .o_slot_waddr  (slot_waddr),
        .o_slot_raddr  (slot_raddr),
        .o_wt_wdata    (wt_wdata),
        .o_rw_wdata    (rw_wdata),
        .o_cnt_addr    (cnt_addr),
        .o_cnt_wdata   (cnt_wdata),
        .i_wt_rdata    (wt_rdata),
        .i_rw_rdata    (rw_rdata),
        .i_cnt_rdata   (cnt_rdata)
    );

    // weight, running weight and peer count storage
    swrr_mem #(
        .MAX_GROUPS  (MAX_GROUPS),
        .MAX_PEERS   (MAX_PEERS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_mem (
        .i_clk        (i_clk),
        .i_ctl        (mem_ctl),
        .i_slot_waddr (slot_waddr),
        .i_slot_raddr (slot_raddr),
        .i_wt_wdata   (wt_wdata),
        .i_rw_wdata   (rw_wdata),
        .i_cnt_addr   (cnt_addr),
        .i_cnt_wdata  (cnt_wdata),
        .o_wt_rdata   (wt_rdata),
        .o_rw_rdata   (rw_rdata),
        .o_cnt_rdata  (cnt_rdata)
    );

endmodule
